// ===== rtl/bdlp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and codes for the button debounce and long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG     = 1'b1;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_TAP  = 2'd1;
	localparam logic [1:0] EV_HOLD = 2'd2;

	typedef struct packed {
		logic        button_select;
		logic        pressed;
		logic [31:0] now_ms;
		logic        is_power;
	} sample_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic       activity;
		logic       power_off;
	} result_t;

	typedef struct packed {
		logic [15:0] debounce_time_ms;
		logic [15:0] long_press_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_long_press.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounce and long-press detector for up to NUM_BUTTONS buttons.
// ----------------------------------------------------------------------------
// Takes one button sample per clock and returns exactly one result beat per
// sample. A sample accepted into the input register runs through the
// per-button phase machine and moves into the result register when that
// register is empty or being drained, so its result is registered. With no
// stall on the result side a new sample is taken every cycle; when the result
// side stalls while both the input and the result register are full,
// sample_stall rises in that same cycle, so at most two samples wait inside
// the block. Write the thresholds over APB only while no sample is in flight.
module button_debounce_long_press (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [bdlp_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire  [bdlp_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [bdlp_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  wire                               sample_valid,
	output logic                              sample_stall,
	input  wire bdlp_pkg::sample_t            sample,
	output logic                              result_valid,
	input  wire                               result_stall,
	output bdlp_pkg::result_t                 result
);
	import bdlp_pkg::*;

	cfg_t cfg;

	bdlp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdlp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== rtl/bdlp_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_cfg
// APB register file holding the debounce and long-press thresholds.
// ----------------------------------------------------------------------------
module bdlp_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [bdlp_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire  [bdlp_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [bdlp_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output bdlp_pkg::cfg_t                    cfg
);
	import bdlp_pkg::*;

	logic [15:0] debounce_q;
	logic [15:0] long_q;
	logic        reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= 16'd30;
			long_q     <= 16'd1000;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE: debounce_q <= pwdata[15:0];
				REG_LONG:     long_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			REG_LONG:     prdata = {16'd0, long_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.debounce_time_ms = debounce_q;
	assign cfg.long_press_ms    = long_q;

endmodule

`default_nettype wire

// ===== rtl/bdlp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_core
// Sample register, per-button phase machines and result register.
// ----------------------------------------------------------------------------
module bdlp_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire bdlp_pkg::cfg_t     cfg,
	input  wire                 sample_valid,
	output logic                sample_stall,
	input  wire bdlp_pkg::sample_t  sample,
	output logic                result_valid,
	input  wire                 result_stall,
	output bdlp_pkg::result_t   result
);
	import bdlp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_SETTLE   = 2'd1,
		PH_DOWN     = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	logic     s1_valid_s1;
	sample_t  s1_data_s1;

	phase_t       phase_q [NUM_BUTTONS];
	logic [31:0]  start_q [NUM_BUTTONS];

	logic         result_valid_q;
	result_t      result_q;

	logic                 adv;
	logic                 take;
	logic [BTN_IDX_W-1:0] btn_idx;
	phase_t               phase_cur;
	phase_t               phase_nxt;
	logic [31:0]          elapsed;
	logic                 start_wr;
	logic [1:0]           ev;
	result_t              res_nxt;

	// move the held sample into the result register when it is free
	assign adv          = s1_valid_s1 & (~result_valid_q | ~result_stall);
	assign sample_stall = s1_valid_s1 & ~adv;
	assign take         = sample_valid & ~sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (take) begin
			s1_valid_s1 <= 1'b1;
		end else if (adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_data_s1 <= sample;
		end
	end

	// out-of-range select falls back to the last button
	always_comb begin
		if (32'(s1_data_s1.button_select) < 32'(NUM_BUTTONS)) begin
			btn_idx = BTN_IDX_W'(s1_data_s1.button_select);
		end else begin
			btn_idx = BTN_IDX_W'(NUM_BUTTONS - 1);
		end
	end

	always_comb begin
		phase_cur = phase_q[btn_idx];
		elapsed   = s1_data_s1.now_ms - start_q[btn_idx];
		phase_nxt = phase_cur;
		start_wr  = 1'b0;
		ev        = EV_NONE;
		unique case (phase_cur)
			PH_IDLE: begin
				if (s1_data_s1.pressed) begin
					phase_nxt = PH_SETTLE;
					start_wr  = 1'b1;
				end
			end
			PH_SETTLE: begin
				if (!s1_data_s1.pressed) begin
					phase_nxt = PH_IDLE;
				end else if (elapsed >= 32'(cfg.debounce_time_ms)) begin
					phase_nxt = PH_DOWN;
				end
			end
			PH_DOWN: begin
				// long check wins over release
				if (elapsed >= 32'(cfg.long_press_ms)) begin
					phase_nxt = PH_LONG;
					ev        = EV_HOLD;
				end else if (!s1_data_s1.pressed) begin
					phase_nxt = PH_IDLE;
					ev        = EV_TAP;
				end
			end
			PH_LONG: begin
				if (!s1_data_s1.pressed) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
		res_nxt.event_code = ev;
		res_nxt.activity   = (ev != EV_NONE);
		res_nxt.power_off  = s1_data_s1.is_power & (ev == EV_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				phase_q[i] <= PH_IDLE;
			end
			result_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q[btn_idx] <= phase_nxt;
				result_valid_q   <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && start_wr) begin
			start_q[btn_idx] <= s1_data_s1.now_ms;
		end
		if (adv) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_activity_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.activity == (result_q.event_code != EV_NONE)))
		else $error("activity flag disagrees with event code");

	a_power_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.power_off |-> result_q.event_code == EV_HOLD)
		else $error("power-off without a long event");

	a_hold_sets_long: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ev == EV_HOLD |=> phase_q[$past(btn_idx)] == PH_LONG)
		else $error("long event did not move button to long phase");

	a_stall_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> s1_valid_s1 && result_valid_q && result_stall)
		else $error("sample stalled with free pipeline");

endmodule

`default_nettype wire

// ===== sim/button_debounce_long_press_test.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_test
// Self-checking bench for the two-button debounce and long-press detector.
// Drives button samples over the valid/stall input, mirrors the per-button
// phase machine in a local predictor and compares every result beat field by
// field. Thresholds are written over APB between traffic phases, including
// both zero and full-scale settings, and the traffic runs with and without
// random idling on either side plus one long result-side hold-off.
// ----------------------------------------------------------------------------
module button_debounce_long_press_test;
	import bdlp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum logic [1:0] {PH_IDLE, PH_SETTLE, PH_DOWN, PH_LONG} btn_phase_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;

	button_debounce_long_press u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// mirror of the block's thresholds and per-button state
	logic [15:0] debounce_ms = 16'd30;
	logic [15:0] long_ms     = 16'd1000;
	btn_phase_e  btn_phase [NUM_BUTTONS];
	logic [31:0] press_start [NUM_BUTTONS];

	result_t awaited_events [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_off = 1'b0;

	int error_count = 0;
	int samples_sent = 0;
	int taps_seen = 0;
	int holds_seen = 0;
	int power_offs_seen = 0;
	int threshold_writes = 0;

	// running timestamp and per-button press plan for the random traffic
	logic [31:0] now_t = '0;
	logic        plan_held [NUM_BUTTONS];
	logic [31:0] plan_start [NUM_BUTTONS];
	logic [31:0] plan_len [NUM_BUTTONS];

	initial begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_phase[i] = PH_IDLE;
			press_start[i] = '0;
			plan_held[i] = 1'b0;
			plan_start[i] = '0;
			plan_len[i] = '0;
		end
	end

	function automatic result_t next_button_event(input sample_t s);
		logic        b;
		logic [31:0] held_ms;
		result_t     r;
		b = s.button_select;
		held_ms = s.now_ms - press_start[b];
		r = '0;
		r.event_code = EV_NONE;
		case (btn_phase[b])
			PH_IDLE: begin
				if (s.pressed) begin
					btn_phase[b] = PH_SETTLE;
					press_start[b] = s.now_ms;
				end
			end
			PH_SETTLE: begin
				if (!s.pressed)
					btn_phase[b] = PH_IDLE;
				else if (held_ms >= {16'h0, debounce_ms})
					btn_phase[b] = PH_DOWN;
			end
			PH_DOWN: begin
				// long check wins over release
				if (held_ms >= {16'h0, long_ms}) begin
					btn_phase[b] = PH_LONG;
					r.event_code = EV_HOLD;
				end else if (!s.pressed) begin
					btn_phase[b] = PH_IDLE;
					r.event_code = EV_TAP;
				end
			end
			default: begin
				if (!s.pressed)
					btn_phase[b] = PH_IDLE;
			end
		endcase
		r.activity = (r.event_code != EV_NONE);
		r.power_off = s.is_power && (r.event_code == EV_HOLD);
		return r;
	endfunction

	task automatic note_error(input string msg);
		if (error_count < 10)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// predict on sample acceptance, check on result acceptance
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				awaited_events.push_back(next_button_event(sample));
			if (result_valid && !result_stall) begin
				if (awaited_events.size() == 0) begin
					note_error($sformatf("result beat with nothing outstanding: code %0d",
						result.event_code));
				end else begin
					want = awaited_events.pop_front();
					if (result.event_code !== want.event_code ||
						result.activity !== want.activity ||
						result.power_off !== want.power_off)
						note_error($sformatf({"event_code exp %0d got %0d, ",
							"activity exp %0b got %0b, power_off exp %0b got %0b"},
							want.event_code, result.event_code, want.activity,
							result.activity, want.power_off, result.power_off));
					if (want.event_code == EV_TAP)
						taps_seen++;
					if (want.event_code == EV_HOLD)
						holds_seen++;
					if (want.power_off)
						power_offs_seen++;
				end
			end
		end
	end

	always @(negedge clk)
		result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, awaited_events.size());
		$display("button_debounce_long_press_test failed");
		$finish;
	end

	task automatic send_sample(input logic btn, input logic lvl, input logic [31:0] t,
		input logic pwr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{button_select: btn, pressed: lvl, now_ms: t, is_power: pwr};
		do @(posedge clk); while (sample_stall);
		samples_sent++;
	endtask

	// drop valid and wait until every result beat has come back
	task automatic settle_block();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_threshold(input logic idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_DEBOUNCE)
			debounce_ms = val;
		else
			long_ms = val;
		threshold_writes++;
		// read back through a second transfer
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val)
			note_error($sformatf("register %0d read back %0h, wrote %0h", idx, prdata[15:0], val));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_thresholds(input logic [15:0] deb, input logic [15:0] lng);
		settle_block();
		write_threshold(REG_DEBOUNCE, deb);
		write_threshold(REG_LONG, lng);
	endtask

	// well-formed press/hold/release plans per button, with some glitches,
	// timestamp jumps and power-flag flips mixed in
	task automatic drive_presses(input int count);
		logic        b;
		logic        lvl;
		logic        pwr;
		int unsigned span;
		span = ((debounce_ms > long_ms) ? debounce_ms : long_ms) + 4;
		now_t = $urandom;
		for (int i = 0; i < count; i++) begin
			b = 1'($urandom_range(1));
			if ($urandom_range(19) == 0)
				now_t = $urandom;
			else
				now_t += $urandom_range(span / 6 + 1);
			if (!plan_held[b]) begin
				if ($urandom_range(2) == 0) begin
					plan_held[b] = 1'b1;
					plan_start[b] = now_t;
					plan_len[b] = $urandom_range(span * 3 / 2);
				end
			end else if (now_t - plan_start[b] >= plan_len[b]) begin
				plan_held[b] = 1'b0;
			end
			lvl = plan_held[b];
			if ($urandom_range(19) == 0)
				lvl = ~lvl;
			pwr = b ^ ($urandom_range(9) == 0);
			send_sample(b, lvl, now_t, pwr);
		end
	endtask

	// reset thresholds: short press, tap, long press on power with a
	// timestamp wrap, and a timestamp running backwards
	task automatic test_reset_defaults();
		send_sample(1'b0, 1'b0, 32'd0, 1'b0);
		send_sample(1'b0, 1'b1, 32'd100, 1'b0);
		send_sample(1'b0, 1'b1, 32'd110, 1'b0);
		send_sample(1'b0, 1'b0, 32'd115, 1'b0);
		send_sample(1'b0, 1'b1, 32'd200, 1'b0);
		send_sample(1'b0, 1'b1, 32'd230, 1'b0);
		send_sample(1'b0, 1'b0, 32'd240, 1'b0);
		send_sample(1'b1, 1'b1, 32'hFFFF_FFF0, 1'b1);
		send_sample(1'b1, 1'b1, 32'h0000_0020, 1'b1);
		send_sample(1'b1, 1'b1, 32'h0000_03D8, 1'b1);
		send_sample(1'b1, 1'b0, 32'h0000_03E0, 1'b1);
		send_sample(1'b0, 1'b1, 32'd5000, 1'b0);
		send_sample(1'b0, 1'b1, 32'd4999, 1'b0);
		send_sample(1'b0, 1'b1, 32'd4998, 1'b0);
		send_sample(1'b0, 1'b0, 32'd4998, 1'b0);
	endtask

	task automatic test_zero_thresholds();
		set_thresholds(16'd0, 16'd0);
		send_sample(1'b0, 1'b1, 32'h1234_5678, 1'b1);
		send_sample(1'b0, 1'b1, 32'h1234_5678, 1'b1);
		send_sample(1'b0, 1'b1, 32'h1234_5678, 1'b1);
		send_sample(1'b0, 1'b0, 32'h1234_5679, 1'b1);
		send_sample(1'b1, 1'b1, 32'h8000_0000, 1'b0);
		send_sample(1'b1, 1'b0, 32'h8000_0000, 1'b0);
	endtask

	task automatic test_max_thresholds();
		set_thresholds(16'hFFFF, 16'hFFFF);
		send_sample(1'b1, 1'b1, 32'd0, 1'b1);
		send_sample(1'b1, 1'b1, 32'd65534, 1'b1);
		send_sample(1'b1, 1'b1, 32'd65535, 1'b1);
		send_sample(1'b1, 1'b1, 32'd65535, 1'b1);
		send_sample(1'b1, 1'b0, 32'd70000, 1'b1);
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
		input logic [15:0] deb, input logic [15:0] lng);
		set_thresholds(deb, lng);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		drive_presses(count);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// hold the result side off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		set_thresholds(16'($urandom_range(10)), 16'($urandom_range(60)));
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		drive_presses(100);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_zero_thresholds();
		test_max_thresholds();
		test_random_traffic(300, 0, 0, 16'd30, 16'd1000);
		test_random_traffic(300, 78, 0, 16'($urandom_range(15)), 16'($urandom_range(60)));
		test_random_traffic(300, 0, 78, 16'd0, 16'hFFFF);
		test_random_traffic(300, 12, 12, 16'hFFFF, 16'($urandom_range(65535)));
		test_backpressure();

		settle_block();
		repeat (5) @(posedge clk);
		if (awaited_events.size() != 0)
			note_error($sformatf("%0d results never arrived", awaited_events.size()));
		$display("covered %0d samples, %0d threshold writes: %0d taps, %0d long presses",
			samples_sent, threshold_writes, taps_seen, holds_seen);
		$display("%0d power-offs seen", power_offs_seen);
		$display("errors: %0d", error_count);
		if (error_count == 0)
			$display("button_debounce_long_press_test passed");
		else
			$display("button_debounce_long_press_test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bdlp_pkg.sv
rtl/bdlp_cfg.sv
rtl/bdlp_core.sv
rtl/button_debounce_long_press.sv
sim/button_debounce_long_press_test.sv
